// ===== rtl/slfo_pkg.sv =====
// ============================================================================
// slfo_pkg - shared definitions for the sine LFO bipolar modulator
// Widths, reset values, register indexes and the quarter-wave sine function.
// ============================================================================
package slfo_pkg;

  // Default sizing
  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SAMPLE_WIDTH_DEF    = 16;

  // Configuration channel
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 32;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PHASE_INCREMENT = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MOD_DEPTH       = 2'd1;

  localparam int PHASE_WIDTH     = 32;
  localparam int PHASE_INC_WIDTH = 31;
  localparam int DEPTH_WIDTH     = 16;
  localparam int DEPTH_MAG_WIDTH = 15;
  localparam int LFO_WIDTH       = 16;
  localparam int LFO_MAG_WIDTH   = 15;

  localparam logic [PHASE_INC_WIDTH-1:0] PHASE_INC_RESET = 31'd447392;
  localparam logic [DEPTH_MAG_WIDTH-1:0] DEPTH_MAG_MAX   = 15'h7fff;

  // 0.1 in Q17 (used as p * FM_SCALE >> 16 on a Q30 product)
  localparam logic [14:0] FM_SCALE = 15'd13107;

  // Q30 Taylor coefficients of sin(pi/2 * t)
  localparam logic [63:0] COEF_C1 = 64'd1686629714;
  localparam logic [63:0] COEF_C3 = 64'd693598669;
  localparam logic [63:0] COEF_C5 = 64'd85569305;
  localparam logic [63:0] COEF_C7 = 64'd5026997;
  localparam logic [63:0] COEF_C9 = 64'd172272;

  // Sine magnitude for a quarter-wave position r (0..65536 stands for 0..pi/2).
  // Evaluated on constant arguments only, to build the lookup table.
  function automatic logic [LFO_MAG_WIDTH-1:0] sine_mag(input logic [16:0] r);
    logic [63:0] rr;
    logic [63:0] t2;
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] v;
    rr = 64'(r);
    t2 = (rr * rr) >> 2;
    a  = COEF_C7 - ((t2 * COEF_C9) >> 30);
    a  = COEF_C5 - ((t2 * a) >> 30);
    a  = COEF_C3 - ((t2 * a) >> 30);
    a  = COEF_C1 - ((t2 * a) >> 30);
    s  = (rr * a) >> 16;
    v  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[LFO_MAG_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/slfo_channels.sv =====
// ============================================================================
// slfo_channels - valid/ready channels of the sine LFO modulator
// Sample channels in and out, and the configuration write channel.
// ============================================================================
interface slfo_dry_if #(
  parameter int SAMPLE_WIDTH = slfo_pkg::SAMPLE_WIDTH_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface slfo_wet_if #(
  parameter int SAMPLE_WIDTH = slfo_pkg::SAMPLE_WIDTH_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [SAMPLE_WIDTH:0] sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface slfo_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [slfo_pkg::CFG_INDEX_WIDTH-1:0]  index;
  logic [slfo_pkg::CFG_DATA_WIDTH-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sine_lfo_bipolar_modulator_unit.sv =====
// ============================================================================
// sine_lfo_bipolar_modulator_unit - sine LFO gain modulator
// Scales each audio sample by 1 + lfo*|depth|*0.5 (negative depth) or
// 1 + lfo*depth*0.1 (positive depth), with a 32-bit wrapping phase LFO.
// ============================================================================
//
//  channel | role   | payload                      | ready
//  --------+--------+------------------------------+-------------------------
//  cfg     | sink   | index, data (register write) | always high
//  dry     | sink   | sample_in, SAMPLE_WIDTH bits | high in the idle state
//  wet     | source | sample_out, SAMPLE_WIDTH+1   | from the downstream side
//
//  Each sample takes one multiply-accumulate pass per product on a single
//  shared unit, stepping idle, gain, fin for negative or zero depth and
//  idle, scale, gain, fin for positive depth (the extra 0.1 scaling pass).
//  Reset (rst, synchronous) clears the phase, restores the register reset
//  values and empties the output register.
//  A finished sample waits in the output register; the next sample is taken
//  meanwhile, and the unit only holds in its last step if that register is
//  still full when the following result is ready.
//
module sine_lfo_bipolar_modulator_unit #(
  parameter int SINE_TABLE_BITS = slfo_pkg::SINE_TABLE_BITS_DEF,
  parameter int SAMPLE_WIDTH    = slfo_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  slfo_cfg_if.sink    cfg,
  slfo_dry_if.sink    dry,
  slfo_wet_if.source  wet
);

  // Quarter-wave table: QN+1 entries cover 0..pi/2 inclusive.
  localparam int QN     = 1 << (SINE_TABLE_BITS - 2);
  localparam int KW     = SINE_TABLE_BITS - 1;
  localparam int RSHIFT = 18 - SINE_TABLE_BITS;

  // Shared multiplier operand widths: A holds the LFO or the Q30/Q31 gain offset,
  // B holds the depth, the 0.1 scale or the sample.
  localparam int AW_A = 32;
  localparam int BW   = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;
  localparam int AW   = AW_A + BW;

  localparam logic signed [AW-1:0] RND_16 = AW'(1) <<< 15;
  localparam logic signed [AW-1:0] RND_31 = AW'(1) <<< 30;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCALE = 4'b0010,
    S_GAIN  = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [slfo_pkg::PHASE_WIDTH-1:0]     phase;
  logic [slfo_pkg::PHASE_INC_WIDTH-1:0] phase_inc;
  logic [slfo_pkg::DEPTH_MAG_WIDTH-1:0] depth_mag;
  logic                                 depth_pos;

  logic signed [slfo_pkg::LFO_WIDTH-1:0] lfo, lfo_next;
  logic signed [SAMPLE_WIDTH-1:0]        x;
  logic signed [AW-1:0]                  acc;
  logic                                  wet_valid;
  logic signed [SAMPLE_WIDTH:0]          wet_data;

  logic dry_beat, cfg_beat, out_free, acc_load;

  // ---------------------------------------------------------------------------
  // Sine lookup: constant table, mirrored for odd quadrants, negated for the
  // second half cycle. Registered into lfo in the cycle after the phase changes,
  // and always settled by the time the unit is idle again.
  // ---------------------------------------------------------------------------
  logic [slfo_pkg::LFO_MAG_WIDTH-1:0] qtab [QN+1];

  for (genvar k = 0; k < QN + 1; k++) begin : g_qtab
    assign qtab[k] = slfo_pkg::sine_mag(17'(k) << RSHIFT);
  end

  logic [SINE_TABLE_BITS-1:0] tab_idx;
  logic [1:0]                 quad;
  logic [KW-1:0]              k_lin, k_sel;
  logic [slfo_pkg::LFO_MAG_WIDTH-1:0] mag;

  always_comb begin
    tab_idx = phase[slfo_pkg::PHASE_WIDTH-1 -: SINE_TABLE_BITS];
    quad    = tab_idx[SINE_TABLE_BITS-1 -: 2];
    k_lin   = {1'b0, tab_idx[SINE_TABLE_BITS-3:0]};
    k_sel   = quad[0] ? (KW'(QN) - k_lin) : k_lin;
    mag     = qtab[k_sel];
    lfo_next = quad[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
  end

  // ---------------------------------------------------------------------------
  // Configuration decode: keep depth as a clamped magnitude and a mode flag.
  // ---------------------------------------------------------------------------
  logic signed [slfo_pkg::DEPTH_WIDTH-1:0] cfg_depth, cfg_depth_neg;
  logic [slfo_pkg::DEPTH_MAG_WIDTH-1:0]    cfg_mag;
  logic                                    cfg_pos;

  always_comb begin
    cfg_depth     = signed'(cfg.data[slfo_pkg::DEPTH_WIDTH-1:0]);
    cfg_depth_neg = -cfg_depth;
    cfg_pos       = !cfg_depth[slfo_pkg::DEPTH_WIDTH-1] && (cfg_depth != '0);
    if (!cfg_depth[slfo_pkg::DEPTH_WIDTH-1]) begin
      cfg_mag = cfg_depth[slfo_pkg::DEPTH_MAG_WIDTH-1:0];
    end else if (cfg_depth_neg[slfo_pkg::DEPTH_WIDTH-1]) begin
      // most negative code: clamp to depth -1
      cfg_mag = slfo_pkg::DEPTH_MAG_MAX;
    end else begin
      cfg_mag = cfg_depth_neg[slfo_pkg::DEPTH_MAG_WIDTH-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiply-accumulate unit: acc <= a * b + rounding constant.
  //   idle  : p = lfo * |depth|            (Q30 offset)
  //   scale : p * 0.1 scale + 2^15         (positive depth only)
  //   gain  : x * m + 2^30, m = p or the scaled term shifted down by 16
  // ---------------------------------------------------------------------------
  logic signed [AW_A-1:0] mul_a;
  logic signed [BW-1:0]   mul_b;
  logic signed [AW-1:0]   mul_add, mul_prod, mul_out;

  assign mul_prod = mul_a * mul_b;
  assign mul_out  = mul_prod + mul_add;

  assign dry_beat = dry.valid && dry.ready;
  assign cfg_beat = cfg.valid && cfg.ready;
  assign out_free = !wet_valid || wet.ready;

  always_comb begin
    state_next = state;
    mul_a      = AW_A'(lfo);
    mul_b      = BW'(signed'({1'b0, depth_mag}));
    mul_add    = '0;
    acc_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (dry_beat) begin
          acc_load   = 1'b1;
          state_next = depth_pos ? S_SCALE : S_GAIN;
        end
      end
      S_SCALE: begin
        mul_a      = signed'(acc[AW_A-1:0]);
        mul_b      = BW'(signed'({1'b0, slfo_pkg::FM_SCALE}));
        mul_add    = RND_16;
        acc_load   = 1'b1;
        state_next = S_GAIN;
      end
      S_GAIN: begin
        mul_a      = depth_pos ? signed'(acc[AW_A+15:16]) : signed'(acc[AW_A-1:0]);
        mul_b      = BW'(x);
        mul_add    = RND_31;
        acc_load   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        // hold until the output register can take the result
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Final add: y = x + floor((x*m + 2^30) / 2^31)
  logic signed [SAMPLE_WIDTH:0] y;
  assign y = (SAMPLE_WIDTH + 1)'(x) + signed'(acc[SAMPLE_WIDTH+31:31]);

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= '0;
      phase_inc <= slfo_pkg::PHASE_INC_RESET;
      depth_mag <= '0;
      depth_pos <= 1'b0;
      lfo       <= '0;
      wet_valid <= 1'b0;
    end else begin
      state <= state_next;
      lfo   <= lfo_next;
      // advance the LFO once per sample beat
      if (dry_beat) begin
        phase <= phase + slfo_pkg::PHASE_WIDTH'(phase_inc);
      end
      if (cfg_beat) begin
        unique case (cfg.index)
          slfo_pkg::REG_PHASE_INCREMENT: begin
            phase_inc <= cfg.data[slfo_pkg::PHASE_INC_WIDTH-1:0];
          end
          slfo_pkg::REG_MOD_DEPTH: begin
            depth_mag <= cfg_mag;
            depth_pos <= cfg_pos;
          end
          default: ;
        endcase
      end
      if ((state == S_FIN) && out_free) begin
        wet_valid <= 1'b1;
      end else if (wet.ready) begin
        wet_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (dry_beat) begin
      x <= dry.sample_in;
    end
    if (acc_load) begin
      acc <= mul_out;
    end
    if ((state == S_FIN) && out_free) begin
      wet_data <= y;
    end
  end

  assign cfg.ready      = 1'b1;
  assign dry.ready      = (state == S_IDLE);
  assign wet.valid      = wet_valid;
  assign wet.sample_out = wet_data;

endmodule
